### design/ibs_pkg.sv
// Shared sizes, types and state codes of the integer bubble sort block.
package ibs_pkg;

	localparam int DEPTH = 64;
	localparam int WIDTH = 32;
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef logic signed [WIDTH-1:0] ibs_val_t;

	// Per-cycle command broadcast to every cell of the chain.
	typedef struct packed {
		logic insert;	// place the incoming element in sorted position
		logic shift;	// move every element one cell toward the head
	} ibs_cmd_t;

	typedef enum logic {
		ST_FILL,
		ST_DRAIN
	} ibs_state_t;

endpackage

### design/ibs_cell.sv
// One sorting cell: holds one element and trades with its neighbors.
module ibs_cell
	import ibs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  ibs_cmd_t cmd,
	input  ibs_val_t new_val,
	input  logic     left_keep,
	input  ibs_val_t left_val,
	input  logic     left_occ,
	input  ibs_val_t right_val,
	input  logic     right_occ,
	output logic     keep,
	output ibs_val_t val,
	output logic     occ
);

	ibs_val_t val_q;
	logic     occ_q;

	// Hold when occupied and not greater than the newcomer: equal values stay ahead.
	assign keep = occ_q && !(val_q > new_val);
	assign val  = val_q;
	assign occ  = occ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (cmd.shift) begin
			occ_q <= right_occ;
		end else if (cmd.insert && !keep) begin
			occ_q <= left_keep ? 1'b1 : left_occ;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			val_q <= right_val;
		end else if (cmd.insert && !keep) begin
			val_q <= left_keep ? new_val : left_val;
		end
	end

endmodule

### design/integer_bubble_sort.sv
// Top level of the integer sorter: insertion chain, fill/drain control, output register.
//
//   channel | signals                              | direction | transfer when
//   --------+--------------------------------------+-----------+---------------------
//   in      | value[31:0] signed, last             | into      | in_valid & in_ready
//   out     | value_res[31:0] signed, last_res,    | out of    | out_valid & out_ready
//           | dropped                              |           |
//
// Fill: one element per cycle; each element that finds room lands in its sorted place
// in the chain in the cycle it transfers, since every cell compares against it at once.
// Drain: after the element flagged last, the set leaves from the head cell, one
// result per cycle while out_ready holds; input is held off until the set's last is loaded.
// A new set may start while the final result still waits in the output register.
// Reset empties the chain and clears counters; element values need no reset.
module integer_bubble_sort
	import ibs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  ibs_val_t value,
	input  logic     last,
	output logic     out_valid,
	input  logic     out_ready,
	output ibs_val_t value_res,
	output logic     last_res,
	output logic     dropped
);

	ibs_state_t state_q, state_nxt;
	logic [CNT_W-1:0] count_q;
	logic             overflow_q;

	logic     out_valid_q;
	ibs_val_t value_res_q;
	logic     last_res_q;
	logic     dropped_q;

	logic     in_fire;
	logic     room;
	logic     load;
	ibs_cmd_t cmd;

	// Chain taps: index i is cell i; head at 0.
	logic     keep_w [DEPTH];
	ibs_val_t val_w  [DEPTH];
	logic     occ_w  [DEPTH];

	assign in_ready = (state_q == ST_FILL);
	assign in_fire  = in_valid && in_ready;
	assign room     = (count_q < CNT_W'(DEPTH));

	// While draining, advance the output register whenever it is empty or being taken.
	assign load = (state_q == ST_DRAIN) && (!out_valid_q || out_ready);

	assign cmd.insert = in_fire && room;
	assign cmd.shift  = load;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic     lk, lo, ro;
			ibs_val_t lv, rv;
			if (gi == 0) begin : g_head
				assign lk = 1'b1;
				assign lv = '0;
				assign lo = 1'b1;
			end else begin : g_mid
				assign lk = keep_w[gi-1];
				assign lv = val_w[gi-1];
				assign lo = occ_w[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_tail
				assign rv = '0;
				assign ro = 1'b0;
			end else begin : g_body
				assign rv = val_w[gi+1];
				assign ro = occ_w[gi+1];
			end
			ibs_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.cmd       (cmd),
				.new_val   (value),
				.left_keep (lk),
				.left_val  (lv),
				.left_occ  (lo),
				.right_val (rv),
				.right_occ (ro),
				.keep      (keep_w[gi]),
				.val       (val_w[gi]),
				.occ       (occ_w[gi])
			);
		end
	endgenerate

	// Next state: drain after the flagged element, return once the last one is loaded.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_FILL: begin
				if (in_fire && last) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (load && count_q == CNT_W'(1)) begin
					state_nxt = ST_FILL;
				end
			end
			default: state_nxt = ST_FILL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Count held elements; flag any element dropped for lack of room.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else if (load) begin
			count_q <= count_q - CNT_W'(1);
			if (count_q == CNT_W'(1)) begin
				overflow_q <= 1'b0;
			end
		end else if (in_fire) begin
			if (room) begin
				count_q <= count_q + CNT_W'(1);
			end else begin
				overflow_q <= 1'b1;
			end
		end
	end

	// Output register: valid flag under reset, payload loaded from the head cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			value_res_q <= val_w[0];
			last_res_q  <= (count_q == CNT_W'(1));
			dropped_q   <= overflow_q;
		end
	end

	assign out_valid = out_valid_q;
	assign value_res = value_res_q;
	assign last_res  = last_res_q;
	assign dropped   = dropped_q;

	// Head cell is occupied exactly when elements are held.
	a_head_occ: assert property (@(posedge clk) disable iff (!arst_n)
		occ_w[0] == (count_q != '0))
		else $error("head occupancy disagrees with element count");

	// Never hold more elements than cells.
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("element count beyond chain depth");

	// Draining always has something left to send.
	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |-> count_q != '0)
		else $error("drain with empty chain");

	// Hold a waiting result steady until it transfers.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value_res) && $stable(last_res)
			&& $stable(dropped))
		else $error("waiting result changed before transfer");

endmodule

### tb/sv/integer_bubble_sort_tb.sv
// Self-checking testbench of the integer sorter: directed, capacity, random and backpressure tests.
module integer_bubble_sort_tb;
	import ibs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam ibs_val_t VAL_MAX = {1'b0, {(WIDTH-1){1'b1}}};
	localparam ibs_val_t VAL_MIN = {1'b1, {(WIDTH-1){1'b0}}};

	// One sorted element as it should leave the block.
	typedef struct {
		ibs_val_t value;
		logic     last;
		logic     dropped;
	} sorted_elem_t;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	ibs_val_t value;
	logic     last;
	logic     out_valid;
	logic     out_ready;
	ibs_val_t value_res;
	logic     last_res;
	logic     dropped;

	// Shadow of the block: elements held for the open set and the drop flag.
	ibs_val_t     held_elems[$];
	logic         set_overflow;
	// Sorted elements still owed by the block, oldest first.
	sorted_elem_t sorted_due_q[$];

	int mismatch_count;
	// Idle rates in percent for each side; zero means no idling.
	int send_idle_pct;
	int recv_idle_pct;
	// Cycles the receiver still holds out_ready low on request.
	int recv_hold_left;

	integer_bubble_sort uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value_res (value_res),
		.last_res  (last_res),
		.dropped   (dropped)
	);

	// 2 ns clock.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Absorb one accepted element into the shadow set. On the closing element,
	// sort the held elements (stable, ascending, signed) and queue them as the
	// results the block owes.
	function automatic void sort_set_accept(input ibs_val_t v, input logic is_last);
		ibs_val_t     sorted[$];
		ibs_val_t     cur;
		int           j;
		sorted_elem_t rec;
		if (held_elems.size() < DEPTH)
			held_elems.push_back(v);
		else
			set_overflow = 1'b1;
		if (!is_last)
			return;
		sorted = held_elems;
		// Insertion sort: move only past strictly greater values, so equal
		// values keep their arrival order.
		for (int i = 1; i < sorted.size(); i++) begin
			cur = sorted[i];
			j = i;
			while (j > 0 && sorted[j-1] > cur) begin
				sorted[j] = sorted[j-1];
				j--;
			end
			sorted[j] = cur;
		end
		foreach (sorted[k]) begin
			rec.value   = sorted[k];
			rec.last    = (k == sorted.size() - 1);
			rec.dropped = set_overflow;
			sorted_due_q.push_back(rec);
		end
		held_elems.delete();
		set_overflow = 1'b0;
	endfunction

	// Offer one element and hold it until the transfer. The caller sits at a
	// rising edge; valid stays high afterwards so back-to-back elements need
	// no second assignment in the same step.
	task automatic send_elem(input ibs_val_t v, input logic is_last);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		value    <= v;
		last     <= is_last;
		// in_ready read right after the edge is the value the block saw at it.
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sort_set_accept(v, is_last);
	endtask

	// Drop valid and wait until every owed result has left the block.
	task automatic wait_sets_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sorted_due_q.size() > 0)
			@(posedge clk);
	endtask

	// Random element: mostly full-range, some clustered near zero so equal
	// values show up, some at the extremes.
	function automatic ibs_val_t rand_elem();
		case ($urandom_range(9))
			5, 6:    return ibs_val_t'($signed($urandom_range(8)) - 4);
			7: begin
				case ($urandom_range(3))
					0:       return VAL_MAX;
					1:       return VAL_MIN;
					2:       return '0;
					default: return '1;
				endcase
			end
			default: return ibs_val_t'($urandom);
		endcase
	endfunction

	// Send a whole set; last goes on its final element.
	task automatic send_set(input int n);
		for (int i = 0; i < n; i++)
			send_elem(rand_elem(), i == n - 1);
	endtask

	// Extremes, single-element sets, ties, reversed and presorted sets.
	task automatic test_directed();
		send_elem(VAL_MAX, 1'b1);
		send_elem(VAL_MIN, 1'b1);
		send_elem(VAL_MAX, 1'b0);
		send_elem(VAL_MIN, 1'b0);
		send_elem('0, 1'b0);
		send_elem('1, 1'b0);
		send_elem(ibs_val_t'(1), 1'b0);
		send_elem(VAL_MIN, 1'b0);
		send_elem(VAL_MAX, 1'b1);
		// ties
		send_elem(ibs_val_t'(5), 1'b0);
		send_elem(ibs_val_t'(5), 1'b0);
		send_elem(ibs_val_t'(5), 1'b1);
		// descending input
		send_elem(ibs_val_t'(3), 1'b0);
		send_elem(ibs_val_t'(2), 1'b0);
		send_elem(ibs_val_t'(1), 1'b0);
		send_elem(ibs_val_t'(-7), 1'b1);
		// already ascending input
		send_elem(ibs_val_t'(-2), 1'b0);
		send_elem(ibs_val_t'(-1), 1'b0);
		send_elem('0, 1'b1);
		wait_sets_drained();
	endtask

	// Fill the store exactly, then overfill it with the closing element itself
	// among the discarded ones.
	task automatic test_capacity();
		send_set(DEPTH);
		for (int i = 0; i < DEPTH + 2; i++)
			send_elem(rand_elem(), i == DEPTH + 1);
		wait_sets_drained();
	endtask

	// Random sets, mostly short, some long, an occasional overfull one.
	task automatic test_random_sets(input int n_items);
		int sent;
		int n;
		sent = 0;
		while (sent < n_items) begin
			case ($urandom_range(19))
				0:       n = $urandom_range(DEPTH + 3, DEPTH - 1);
				1, 2:    n = $urandom_range(24, 9);
				default: n = $urandom_range(8, 1);
			endcase
			send_set(n);
			sent += n;
		end
		wait_sets_drained();
	endtask

	// Hold the receiver off for a long stretch while sets keep coming, so the
	// drain of the first set stalls and in_ready drops.
	task automatic test_backpressure();
		recv_hold_left = 400;
		for (int s = 0; s < 5; s++)
			send_set($urandom_range(8, 4));
		wait_sets_drained();
	endtask

	// Receiver: random ready, or held low while a hold-off is pending.
	always @(posedge clk) begin
		if (recv_hold_left > 0) begin
			out_ready <= 1'b0;
			recv_hold_left--;
		end else begin
			out_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Check each result transfer against the oldest owed element.
	always @(posedge clk) begin
		sorted_elem_t want;
		if (arst_n && out_valid && out_ready) begin
			if (sorted_due_q.size() == 0) begin
				$display("%0t: unexpected result value_res=%0d last_res=%b dropped=%b",
					$time, value_res, last_res, dropped);
				mismatch_count++;
			end else begin
				want = sorted_due_q.pop_front();
				if (value_res !== want.value) begin
					$display("%0t: value_res expected %0d, got %0d",
						$time, want.value, value_res);
					mismatch_count++;
				end
				if (last_res !== want.last) begin
					$display("%0t: last_res expected %b, got %b", $time, want.last, last_res);
					mismatch_count++;
				end
				if (dropped !== want.dropped) begin
					$display("%0t: dropped expected %b, got %b", $time, want.dropped, dropped);
					mismatch_count++;
				end
			end
		end
	end

	// Hard stop well beyond the slowest correct run.
	initial begin
		#200000;
		$display("FAIL");
		$finish;
	end

	initial begin
		// Known values on every input before the first edge.
		clk            = 1'b0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		value          = '0;
		last           = 1'b0;
		out_ready      = 1'b0;
		set_overflow   = 1'b0;
		mismatch_count = 0;
		recv_hold_left = 0;
		send_idle_pct  = 23;
		recv_idle_pct  = 60;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sender idles lightly, receiver heavily.
		test_directed();
		test_capacity();
		test_random_sets(30);

		// Swap the idle rates.
		send_idle_pct = 60;
		recv_idle_pct = 23;
		test_random_sets(30);
		test_backpressure();

		// Full rate on both sides.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_sets(30);

		wait_sets_drained();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
